/* design/sbm_pkg.sv */
// ----------------------------------------------------------------------------
// sbm_pkg: shared definitions for the slot bitmap
// Default sizes, request mode and status codes, index width helper.
// ----------------------------------------------------------------------------
package sbm_pkg;

   localparam int DEF_WORD_BITS   = 32;
   localparam int DEF_TABLE_WORDS = 1024;
   localparam int DEF_SLOT_ORDER  = 4;

   localparam logic [1:0] MODE_MARK   = 2'd0;
   localparam logic [1:0] MODE_ERASE  = 2'd1;
   localparam logic [1:0] MODE_CLEAR  = 2'd2;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_MISALIGN = 2'd1;
   localparam logic [1:0] STATUS_CONFLICT = 2'd2;
   localparam logic [1:0] STATUS_RANGE    = 2'd3;

   // bits needed to index n entries, at least one
   function automatic int index_bits(input int n);
      return (n > 1) ? $clog2(n) : 1;
   endfunction

endpackage

/* design/sbm_ram.sv */
// ----------------------------------------------------------------------------
// sbm_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sbm_ram
   import sbm_pkg::*;
#(
   parameter int WIDTH = DEF_WORD_BITS,
   parameter int DEPTH = DEF_TABLE_WORDS
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [index_bits(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]             wr_data,
   input  logic [index_bits(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/sbm_div.sv */
// ----------------------------------------------------------------------------
// sbm_div: divider by a constant
// Splits a slot number into word index and bit position by multiplying with
// a rounded-up reciprocal. Start is registered in p1_ff, then in done_ff, which drives done.
// ----------------------------------------------------------------------------
module sbm_div
   import sbm_pkg::*;
#(
   parameter int NUM_W   = 15,
   parameter int DIVISOR = DEF_WORD_BITS,
   parameter int REM_W   = index_bits(DEF_WORD_BITS)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   output logic             done,
   output logic [NUM_W-1:0] quotient,
   output logic [REM_W-1:0] remainder
);

   // a shift of NUM_W + ceil(log2 DIVISOR) keeps the quotient exact for every dividend
   localparam int     SHIFT   = NUM_W + REM_W;
   localparam int     RECIP_W = NUM_W + 2;
   localparam int     PROD_W  = NUM_W + RECIP_W;
   localparam longint RECIP_L = ((longint'(1) << SHIFT) + longint'(DIVISOR) - longint'(1))
                                / longint'(DIVISOR);
   localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'(RECIP_L);
   localparam logic [NUM_W-1:0]   DIV_VAL = NUM_W'(DIVISOR);

   logic              p1_ff, p1_in;
   logic              done_ff, done_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [NUM_W-1:0]  quo_calc;

   assign quo_calc = NUM_W'(prod_ff >> SHIFT);

   always_comb begin
      p1_in   = start;
      done_in = p1_ff;
      prod_in = prod_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         prod_in = PROD_W'(dividend) * PROD_W'(RECIP);
         num_in  = dividend;
      end
      if (p1_ff) begin
         quo_in = quo_calc;
         rem_in = REM_W'(num_ff - quo_calc * DIV_VAL);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         p1_ff   <= p1_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      num_ff  <= num_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

/* design/slot_bitmap_range_mark_erase.sv */
// Steps: states DECODE and RANGE, then two slot divisions (first and last slot),
//   then per bitmap word a check (CHK_RD, CHK_EVAL) and then a write (WR_RD,
//   WR_EVAL), then DONE posts the result. Early failures go from DECODE or RANGE to DONE.
// A clear request sweeps the table RAM, one word a cycle, then posts its result.
// One request at a time: req_stall is high until the result is posted, and DONE waits
//   while rsp_stall holds the output register. Reset runs the same sweep (req_stall high).
// ----------------------------------------------------------------------------
// slot_bitmap_range_mark_erase: slot allocation bitmap with range mark/erase
// Checks a slot range against the table word by word, then marks or erases
// it; a failed check leaves the table untouched.
// ----------------------------------------------------------------------------
module slot_bitmap_range_mark_erase
   import sbm_pkg::*;
#(
   parameter int WORD_BITS   = DEF_WORD_BITS,
   parameter int TABLE_WORDS = DEF_TABLE_WORDS,
   parameter int SLOT_ORDER  = DEF_SLOT_ORDER
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_address,
   input  logic [31:0] req_size,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   localparam int WIDX_W = index_bits(TABLE_WORDS);
   localparam int BIT_W  = index_bits(WORD_BITS);
   localparam int SLOT_W = index_bits(TABLE_WORDS * WORD_BITS);
   localparam logic [35:0] REGION_BYTES = 36'(TABLE_WORDS * WORD_BITS) << SLOT_ORDER;
   localparam logic [31:0] ALIGN_MASK   = 32'((64'd1 << SLOT_ORDER) - 64'd1);
   localparam logic [WORD_BITS-1:0] ALL_ONES = {WORD_BITS{1'b1}};
   localparam logic [WIDX_W-1:0]    LAST_WORD = WIDX_W'(TABLE_WORDS - 1);
   localparam logic [BIT_W-1:0]     TOP_BIT   = BIT_W'(WORD_BITS - 1);

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_DECODE    = 4'd1;
   localparam logic [3:0] ST_RANGE     = 4'd2;
   localparam logic [3:0] ST_DIV_FIRST = 4'd3;
   localparam logic [3:0] ST_DIV_LAST  = 4'd4;
   localparam logic [3:0] ST_CHK_RD    = 4'd5;
   localparam logic [3:0] ST_CHK_EVAL  = 4'd6;
   localparam logic [3:0] ST_WR_RD     = 4'd7;
   localparam logic [3:0] ST_WR_EVAL   = 4'd8;
   localparam logic [3:0] ST_CLEAR     = 4'd9;
   localparam logic [3:0] ST_DONE      = 4'd10;

   logic [3:0]        state_ff, state_in;
   logic [WIDX_W-1:0] w_ff, w_in;
   logic              clr_resp_ff, clr_resp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       region_base_ff, region_base_in;

   logic [1:0]        mode_ff, mode_in;
   logic [31:0]       addr_ff, addr_in;
   logic [31:0]       size_ff, size_in;
   logic [31:0]       off_ff, off_in;
   logic [32:0]       last_ff, last_in;
   logic [WIDX_W-1:0] sw_ff, sw_in, ew_ff, ew_in;
   logic [BIT_W-1:0]  sb_ff, sb_in, eb_ff, eb_in;
   logic [1:0]        status_ff, status_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;

   logic                 req_accept;
   logic [32:0]          last_byte;
   logic [SLOT_W-1:0]    first_slot, last_slot;
   logic                 div_start, div_done;
   logic [SLOT_W-1:0]    div_dividend, div_quo;
   logic [BIT_W-1:0]     div_rem;
   logic                 ram_wr_en;
   logic [WORD_BITS-1:0] ram_wr_data, ram_rd_data;
   logic [WORD_BITS-1:0] lo_mask, hi_mask, word_mask, masked, new_word;
   logic                 range_bad;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   assign last_byte  = {1'b0, off_ff} + {1'b0, size_ff} - 33'd1;
   assign first_slot = SLOT_W'(off_ff >> SLOT_ORDER);
   assign last_slot  = SLOT_W'(last_ff >> SLOT_ORDER);

   assign div_dividend = (state_ff == ST_RANGE) ? first_slot : last_slot;

   // slot bits of the current word that fall inside the range
   assign lo_mask   = (w_ff == sw_ff) ? (ALL_ONES << sb_ff) : ALL_ONES;
   assign hi_mask   = (w_ff == ew_ff) ? (ALL_ONES >> (TOP_BIT - eb_ff)) : ALL_ONES;
   assign word_mask = lo_mask & hi_mask;
   assign masked    = ram_rd_data & word_mask;
   assign new_word  = (mode_ff == MODE_MARK) ? (ram_rd_data | word_mask)
                                             : (ram_rd_data & ~word_mask);
   assign range_bad = (mode_ff == MODE_MARK) ? (masked != '0) : (masked != word_mask);

   assign ram_wr_en   = (state_ff == ST_CLEAR) || (state_ff == ST_WR_EVAL);
   assign ram_wr_data = (state_ff == ST_CLEAR) ? '0 : new_word;

   always_comb begin
      state_in       = state_ff;
      w_in           = w_ff;
      clr_resp_in    = clr_resp_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      region_base_in = csr_wr_en ? csr_wr_data : region_base_ff;
      mode_in        = mode_ff;
      addr_in        = addr_ff;
      size_in        = size_ff;
      off_in         = off_ff;
      last_in        = last_ff;
      sw_in          = sw_ff;
      sb_in          = sb_ff;
      ew_in          = ew_ff;
      eb_in          = eb_ff;
      status_in      = status_ff;
      div_start      = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               mode_in  = req_mode;
               addr_in  = req_address;
               size_in  = req_size;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (mode_ff)
               MODE_CLEAR: begin
                  clr_resp_in = 1'b1;
                  w_in        = '0;
                  state_in    = ST_CLEAR;
               end
               MODE_MARK, MODE_ERASE: begin
                  if ((addr_ff & ALIGN_MASK) != '0) begin
                     status_in = STATUS_MISALIGN;
                     state_in  = ST_DONE;
                  end else if ((addr_ff < region_base_ff) || (size_ff == '0)) begin
                     status_in = STATUS_RANGE;
                     state_in  = ST_DONE;
                  end else begin
                     off_in   = addr_ff - region_base_ff;
                     state_in = ST_RANGE;
                  end
               end
               default: begin
                  status_in = STATUS_OK;
                  state_in  = ST_DONE;
               end
            endcase
         end
         ST_RANGE: begin
            if ({3'b000, last_byte} >= REGION_BYTES) begin
               status_in = STATUS_RANGE;
               state_in  = ST_DONE;
            end else begin
               last_in   = last_byte;
               div_start = 1'b1;
               state_in  = ST_DIV_FIRST;
            end
         end
         ST_DIV_FIRST: begin
            if (div_done) begin
               sw_in     = WIDX_W'(div_quo);
               sb_in     = div_rem;
               w_in      = WIDX_W'(div_quo);
               div_start = 1'b1;
               state_in  = ST_DIV_LAST;
            end
         end
         ST_DIV_LAST: begin
            if (div_done) begin
               ew_in    = WIDX_W'(div_quo);
               eb_in    = div_rem;
               state_in = ST_CHK_RD;
            end
         end
         ST_CHK_RD: begin
            state_in = ST_CHK_EVAL;
         end
         ST_CHK_EVAL: begin
            if (range_bad) begin
               status_in = STATUS_CONFLICT;
               state_in  = ST_DONE;
            end else if (w_ff == ew_ff) begin
               w_in     = sw_ff;
               state_in = ST_WR_RD;
            end else begin
               w_in     = w_ff + WIDX_W'(1);
               state_in = ST_CHK_RD;
            end
         end
         ST_WR_RD: begin
            state_in = ST_WR_EVAL;
         end
         ST_WR_EVAL: begin
            if (w_ff == ew_ff) begin
               status_in = STATUS_OK;
               state_in  = ST_DONE;
            end else begin
               w_in     = w_ff + WIDX_W'(1);
               state_in = ST_WR_RD;
            end
         end
         ST_CLEAR: begin
            if (w_ff == LAST_WORD) begin
               if (clr_resp_ff) begin
                  clr_resp_in = 1'b0;
                  status_in   = STATUS_OK;
                  state_in    = ST_DONE;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               w_in = w_ff + WIDX_W'(1);
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         w_ff           <= '0;
         clr_resp_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         region_base_ff <= '0;
      end else begin
         state_ff       <= state_in;
         w_ff           <= w_in;
         clr_resp_ff    <= clr_resp_in;
         rsp_valid_ff   <= rsp_valid_in;
         region_base_ff <= region_base_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      addr_ff       <= addr_in;
      size_ff       <= size_in;
      off_ff        <= off_in;
      last_ff       <= last_in;
      sw_ff         <= sw_in;
      sb_ff         <= sb_in;
      ew_ff         <= ew_in;
      eb_ff         <= eb_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
   end

   sbm_div #(
      .NUM_W   (SLOT_W),
      .DIVISOR (WORD_BITS),
      .REM_W   (BIT_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   sbm_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (TABLE_WORDS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (w_ff),
      .wr_data (ram_wr_data),
      .rd_addr (w_ff),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;

endmodule
